/* design/assert_macros.svh */
// Assertion macros used by the mailbox top level.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) \
    else $error("mailbox assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) \
    else $error("mailbox assertion failed");

`endif

/* design/mqm_pkg.sv */
// Package for the multi-queue mailbox: sizes, operation codes, entry types and helpers.
// Depends on nothing; used by the mailbox top level.
package mqm_pkg;

  localparam int NUM_QUEUES      = 16;
  localparam int SLOTS_PER_QUEUE = 16;
  localparam int PAYLOAD_BYTES   = 8;

  localparam int QID_W   = 5;
  localparam int TAG_W   = 16;
  localparam int DATA_W  = 64;
  localparam int LEN_W   = 4;
  localparam int QIDX_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SLOT_W  = $clog2(SLOTS_PER_QUEUE);
  localparam int FILL_W  = $clog2(SLOTS_PER_QUEUE + 1);
  localparam int MSG_DEPTH = NUM_QUEUES * SLOTS_PER_QUEUE;
  localparam int MSG_AW  = $clog2(MSG_DEPTH);

  typedef enum logic [1:0] {
    KIND_CREATE  = 2'd0,
    KIND_SEND    = 2'd1,
    KIND_RECV    = 2'd2,
    KIND_DESTROY = 2'd3
  } kind_t;

  // Per-queue ring pointers, held in the pointer memory.
  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic [SLOT_W-1:0] wr;
    logic [SLOT_W-1:0] rd;
  } ptr_entry_t;

  // One message slot, held in the message memory.
  typedef struct packed {
    logic [TAG_W-1:0]  sender;
    logic [TAG_W-1:0]  mtype;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] data;
  } msg_entry_t;

  localparam int PTR_W = $bits(ptr_entry_t);
  localparam int MSG_W = $bits(msg_entry_t);

  // Keeps the bytes below n and clears the rest.
  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < DATA_W / 8; b++) begin
      if (LEN_W'(b) < n) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  // Slot address within the message memory.
  function automatic logic [MSG_AW-1:0] msg_addr(input logic [QIDX_W-1:0] q,
                                                 input logic [SLOT_W-1:0] slot);
    return MSG_AW'(q) * MSG_AW'(SLOTS_PER_QUEUE) + MSG_AW'(slot);
  endfunction

  // Ring successor of a slot number.
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
    return (slot == SLOT_W'(SLOTS_PER_QUEUE - 1)) ? '0 : slot + SLOT_W'(1);
  endfunction

endpackage

/* design/mqm_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; instanced for the pointer and message memories.
module mqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/multi_queue_mailbox.sv */
// Top level of the multi-queue mailbox: control, queue table and memory instances.
// Depends on mqm_pkg, mqm_ram and assert_macros.svh.

// A table of message queues, each a ring of fixed-size slots. A word is accepted
// when start is high and busy is low; every word gives exactly one result, shown
// for one cycle while done is high, and the receiver cannot stall it, so it must
// take the result in that cycle. Create, send, destroy and a refused receive go
// from acceptance through S_PTR to done, and a successful receive goes on through
// S_MSG: S_PTR works on the queue's ring pointers read from the pointer memory,
// and a successful receive spends S_MSG on the registered read of the message
// memory. A new word may be accepted in the cycle that done is high. No clearing
// pass follows reset: the queue table is cleared at once, and a queue's pointers
// are written by create before any use.
`include "assert_macros.svh"

module multi_queue_mailbox (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 kind,
  input  logic [mqm_pkg::QID_W-1:0]  queue_id,
  input  logic [mqm_pkg::TAG_W-1:0]  sender,
  input  logic [mqm_pkg::TAG_W-1:0]  msg_type,
  input  logic [mqm_pkg::DATA_W-1:0] payload,
  input  logic [mqm_pkg::LEN_W-1:0]  send_length,
  input  logic [mqm_pkg::LEN_W-1:0]  recv_limit,
  output logic                       done,
  output logic                       status,
  output logic [mqm_pkg::QID_W-1:0]  new_queue_id,
  output logic [mqm_pkg::TAG_W-1:0]  got_sender,
  output logic [mqm_pkg::TAG_W-1:0]  got_type,
  output logic [mqm_pkg::DATA_W-1:0] got_payload,
  output logic [mqm_pkg::LEN_W-1:0]  got_length
);

  import mqm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PTR, S_MSG} state_t;

  state_t state;

  // Queue table: one in-use flag per queue, cleared by reset.
  logic [NUM_QUEUES-1:0] in_use;

  // The accepted word, held for the length of the operation.
  kind_t             op_kind;
  logic              op_ok;
  logic [QIDX_W-1:0] op_idx;
  logic [TAG_W-1:0]  op_sender;
  logic [TAG_W-1:0]  op_type;
  logic [LEN_W-1:0]  op_len;
  logic [DATA_W-1:0] op_data;
  logic [LEN_W-1:0]  op_limit;

  logic              accept;
  logic [QID_W-1:0]  qid_m1;
  logic [QIDX_W-1:0] idx_in;
  logic              id_ok_in;
  logic [LEN_W-1:0]  len_sat;

  logic              free_found;
  logic [QIDX_W-1:0] free_idx;

  logic              ptr_we;
  logic [QIDX_W-1:0] ptr_waddr;
  ptr_entry_t        ptr_wr_entry;
  logic [PTR_W-1:0]  ptr_rdata;
  ptr_entry_t        ptr_rd;

  logic              msg_we;
  logic              msg_re;
  logic [MSG_AW-1:0] msg_waddr;
  logic [MSG_AW-1:0] msg_raddr;
  msg_entry_t        msg_wr_entry;
  logic [MSG_W-1:0]  msg_rdata;
  msg_entry_t        msg_rd;

  logic              send_ok;
  logic              recv_ok;

  logic              result_clear;

  assign accept = start && !busy;

  // Ids count from one; zero and ids past the table are rejected.
  assign qid_m1   = queue_id - QID_W'(1);
  assign idx_in   = QIDX_W'(qid_m1);
  assign id_ok_in = (queue_id != '0) && (queue_id <= QID_W'(NUM_QUEUES)) && in_use[idx_in];

  // The length is saturated to the payload size before it is stored.
  assign len_sat = (send_length > LEN_W'(PAYLOAD_BYTES)) ? LEN_W'(PAYLOAD_BYTES)
                                                          : send_length;

  // Lowest free queue, searched from the top so that the lowest one wins.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_idx   = QIDX_W'(i);
      end
    end
  end

  assign ptr_rd = ptr_entry_t'(ptr_rdata);
  assign msg_rd = msg_entry_t'(msg_rdata);

  assign send_ok = op_ok && (ptr_rd.fill < FILL_W'(SLOTS_PER_QUEUE));
  assign recv_ok = op_ok && (ptr_rd.fill != '0);

  // Pointer write-back in the cycle after the read. Create starts the new queue
  // empty; send and receive advance one end of the ring.
  always_comb begin
    ptr_we       = 1'b0;
    ptr_waddr    = op_idx;
    ptr_wr_entry = ptr_rd;
    if (state == S_PTR) begin
      case (op_kind)
        KIND_CREATE: begin
          ptr_we       = free_found;
          ptr_waddr    = free_idx;
          ptr_wr_entry = '0;
        end
        KIND_SEND: begin
          ptr_we            = send_ok;
          ptr_wr_entry.fill = ptr_rd.fill + FILL_W'(1);
          ptr_wr_entry.wr   = slot_inc(ptr_rd.wr);
        end
        KIND_RECV: begin
          ptr_we            = recv_ok;
          ptr_wr_entry.fill = ptr_rd.fill - FILL_W'(1);
          ptr_wr_entry.rd   = slot_inc(ptr_rd.rd);
        end
        default: begin
          ptr_we = 1'b0;
        end
      endcase
    end
  end

  assign msg_we    = (state == S_PTR) && (op_kind == KIND_SEND) && send_ok;
  assign msg_re    = (state == S_PTR) && (op_kind == KIND_RECV) && recv_ok;
  assign msg_waddr = msg_addr(op_idx, ptr_rd.wr);
  assign msg_raddr = msg_addr(op_idx, ptr_rd.rd);

  assign msg_wr_entry.sender = op_sender;
  assign msg_wr_entry.mtype  = op_type;
  assign msg_wr_entry.length = op_len;
  assign msg_wr_entry.data   = op_data;

  mqm_ram #(
    .WIDTH (PTR_W),
    .DEPTH (NUM_QUEUES)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (ptr_waddr),
    .wdata (ptr_wr_entry),
    .re    (accept),
    .raddr (idx_in),
    .rdata (ptr_rdata)
  );

  mqm_ram #(
    .WIDTH (MSG_W),
    .DEPTH (MSG_DEPTH)
  ) u_msg_ram (
    .clk   (clk),
    .we    (msg_we),
    .waddr (msg_waddr),
    .wdata (msg_wr_entry),
    .re    (msg_re),
    .raddr (msg_raddr),
    .rdata (msg_rdata)
  );

  // Sequencer, queue table and registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      busy   <= 1'b0;
      done   <= 1'b0;
      in_use <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_kind   <= kind_t'(kind);
            op_ok     <= id_ok_in;
            op_idx    <= idx_in;
            op_sender <= sender;
            op_type   <= msg_type;
            op_len    <= len_sat;
            op_data   <= payload & byte_mask(len_sat);
            op_limit  <= recv_limit;
            busy      <= 1'b1;
            state     <= S_PTR;
          end
        end
        S_PTR: begin
          new_queue_id <= '0;
          got_sender   <= '0;
          got_type     <= '0;
          got_payload  <= '0;
          got_length   <= '0;
          done         <= 1'b1;
          busy         <= 1'b0;
          state        <= S_IDLE;
          unique case (op_kind)
            KIND_CREATE: begin
              status <= !free_found;
              if (free_found) begin
                in_use[free_idx] <= 1'b1;
                new_queue_id     <= QID_W'(free_idx) + QID_W'(1);
              end
            end
            KIND_SEND: begin
              status <= !send_ok;
            end
            KIND_RECV: begin
              // A successful receive waits in S_MSG for the slot.
              status <= !recv_ok;
              if (recv_ok) begin
                done  <= 1'b0;
                busy  <= 1'b1;
                state <= S_MSG;
              end
            end
            KIND_DESTROY: begin
              status <= !op_ok;
              if (op_ok) begin
                in_use[op_idx] <= 1'b0;
              end
            end
          endcase
        end
        S_MSG: begin
          status       <= 1'b0;
          new_queue_id <= '0;
          got_sender   <= msg_rd.sender;
          got_type     <= msg_rd.mtype;
          got_length   <= msg_rd.length;
          got_payload  <= msg_rd.data & byte_mask(op_limit);
          done         <= 1'b1;
          busy         <= 1'b0;
          state        <= S_IDLE;
        end
        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A refused word carries nothing but its status.
  assign result_clear = (new_queue_id == '0) && (got_sender == '0) && (got_type == '0) &&
                        (got_payload == '0) && (got_length == '0);

  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMPLIES(a_done_after_busy, clk, rst, done, $past(busy))
  `ASSERT_IMPLIES(a_fail_zero, clk, rst, done && status, result_clear)
  `ASSERT_IMPLIES(a_fill_bound, clk, rst, ptr_we, ptr_wr_entry.fill <= FILL_W'(SLOTS_PER_QUEUE))

endmodule

/* tb/sv/tb_multi_queue_mailbox.sv */
// Self-checking bench for the multi-queue mailbox: a shadow of the queue table predicts
// each reply, and a directed opening is followed by randomised queue traffic.
// Depends on mqm_pkg and the multi_queue_mailbox RTL.
`timescale 1ns / 100ps

import mqm_pkg::*;

// Shadow copy of the queue table. It predicts the reply of every accepted word
// and compares each reply strobed by the block against the oldest prediction.
class mailbox_shadow;
  typedef struct packed {
    logic              status;
    logic [QID_W-1:0]  new_id;
    logic [TAG_W-1:0]  from;
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } reply_t;

  reply_t replies_due[$];

  bit              live [NUM_QUEUES];
  int              head [NUM_QUEUES];
  int              tail [NUM_QUEUES];
  int              depth[NUM_QUEUES];
  logic [TAG_W-1:0]  slot_from[MSG_DEPTH];
  logic [TAG_W-1:0]  slot_tag [MSG_DEPTH];
  logic [LEN_W-1:0]  slot_len [MSG_DEPTH];
  logic [DATA_W-1:0] slot_data[MSG_DEPTH];

  int errors;
  int words;
  int last_new_id;
  int ops_seen[4];
  int bad_id_refusals, full_refusals, empty_refusals, no_free_refusals;

  // Mask that keeps the low n bytes of a payload word.
  function logic [DATA_W-1:0] low_bytes(int n);
    if (n >= PAYLOAD_BYTES) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function int pick_live();
    int ids[$];
    foreach (live[i]) if (live[i]) ids.push_back(i + 1);
    if (ids.size() == 0) return 0;
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  function int free_count();
    int n;
    n = 0;
    foreach (live[i]) if (!live[i]) n++;
    return n;
  endfunction

  function int fill_of(int id);
    if (id < 1 || id > NUM_QUEUES) return 0;
    return depth[id - 1];
  endfunction

  function int pending();
    return replies_due.size();
  endfunction

  // Applies one accepted word to the shadow table and queues its reply.
  function void take_word(kind_t k, logic [QID_W-1:0] qid, logic [TAG_W-1:0] from,
                          logic [TAG_W-1:0] tag, logic [DATA_W-1:0] data,
                          logic [LEN_W-1:0] slen, logic [LEN_W-1:0] rlim);
    reply_t r;
    int q;
    int at;
    int n;
    bit found;
    r = '0;
    r.status = 1'b1;
    q = -1;
    found = 1'b0;
    if (qid != 0 && int'(qid) <= NUM_QUEUES) begin
      if (live[int'(qid) - 1]) q = int'(qid) - 1;
    end
    words++;
    ops_seen[k]++;
    case (k)
      KIND_CREATE: begin
        for (int i = 0; i < NUM_QUEUES; i++) begin
          if (!found && !live[i]) begin
            found    = 1'b1;
            live[i]  = 1'b1;
            head[i]  = 0;
            tail[i]  = 0;
            depth[i] = 0;
            r.status = 1'b0;
            r.new_id = QID_W'(i + 1);
            last_new_id = i + 1;
          end
        end
        if (!found) no_free_refusals++;
      end
      KIND_SEND: begin
        if (q < 0) bad_id_refusals++;
        else if (depth[q] >= SLOTS_PER_QUEUE) full_refusals++;
        else begin
          n  = (int'(slen) > PAYLOAD_BYTES) ? PAYLOAD_BYTES : int'(slen);
          at = q * SLOTS_PER_QUEUE + tail[q];
          slot_from[at] = from;
          slot_tag[at]  = tag;
          slot_len[at]  = LEN_W'(n);
          slot_data[at] = data & low_bytes(n);
          tail[q]  = (tail[q] + 1) % SLOTS_PER_QUEUE;
          depth[q] = depth[q] + 1;
          r.status = 1'b0;
        end
      end
      KIND_RECV: begin
        if (q < 0) bad_id_refusals++;
        else if (depth[q] == 0) empty_refusals++;
        else begin
          at = q * SLOTS_PER_QUEUE + head[q];
          r.from   = slot_from[at];
          r.tag    = slot_tag[at];
          r.len    = slot_len[at];
          r.data   = slot_data[at] & low_bytes(int'(rlim));
          head[q]  = (head[q] + 1) % SLOTS_PER_QUEUE;
          depth[q] = depth[q] - 1;
          r.status = 1'b0;
        end
      end
      default: begin
        if (q < 0) bad_id_refusals++;
        else begin
          live[q]  = 1'b0;
          r.status = 1'b0;
        end
      end
    endcase
    replies_due.push_back(r);
  endfunction

  function void field_check(string what, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t ns: %s expected %h actual %h", $time, what, exp_v, act_v);
      errors++;
    end
  endfunction

  // Compares one strobed reply with the oldest outstanding prediction.
  function void match_reply(logic st, logic [QID_W-1:0] nid, logic [TAG_W-1:0] from,
                            logic [TAG_W-1:0] tag, logic [DATA_W-1:0] data,
                            logic [LEN_W-1:0] len);
    reply_t e;
    if (replies_due.size() == 0) begin
      $display("%0t ns: reply with none outstanding, status %b", $time, st);
      errors++;
      return;
    end
    e = replies_due.pop_front();
    field_check("status", DATA_W'(e.status), DATA_W'(st));
    field_check("new_queue_id", DATA_W'(e.new_id), DATA_W'(nid));
    field_check("got_sender", DATA_W'(e.from), DATA_W'(from));
    field_check("got_type", DATA_W'(e.tag), DATA_W'(tag));
    field_check("got_payload", e.data, data);
    field_check("got_length", DATA_W'(e.len), DATA_W'(len));
  endfunction
endclass

module tb_multi_queue_mailbox;

  // Idle cycles with nothing accepted on either side before the run is abandoned.
  // The limit is many times the longest sender gap plus the slowest word, and so
  // many times the slowest correct stretch.
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_WORDS = 850;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  kind_t             kind;
  logic [QID_W-1:0]  queue_id;
  logic [TAG_W-1:0]  sender;
  logic [TAG_W-1:0]  msg_type;
  logic [DATA_W-1:0] payload;
  logic [LEN_W-1:0]  send_length;
  logic [LEN_W-1:0]  recv_limit;
  logic              done;
  logic              status;
  logic [QID_W-1:0]  new_queue_id;
  logic [TAG_W-1:0]  got_sender;
  logic [TAG_W-1:0]  got_type;
  logic [DATA_W-1:0] got_payload;
  logic [LEN_W-1:0]  got_length;

  mailbox_shadow shadow = new;

  int idle_cycles;
  bit steady;

  multi_queue_mailbox u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .queue_id     (queue_id),
    .sender       (sender),
    .msg_type     (msg_type),
    .payload      (payload),
    .send_length  (send_length),
    .recv_limit   (recv_limit),
    .done         (done),
    .status       (status),
    .new_queue_id (new_queue_id),
    .got_sender   (got_sender),
    .got_type     (got_type),
    .got_payload  (got_payload),
    .got_length   (got_length)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Every reply is strobed for exactly one cycle and cannot be held off, so it is
  // taken at the rising edge that closes the strobe cycle. Values read here are the
  // ones that stood before the edge.
  always @(posedge clk) begin
    if (!rst && done !== 1'b0) begin
      shadow.match_reply(status, new_queue_id, got_sender, got_type, got_payload,
                         got_length);
    end
  end

  // Watchdog: a word accepted or a reply strobed counts as progress.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles, %0d replies outstanding", $time,
                 IDLE_LIMIT, shadow.pending());
        $display("tb_multi_queue_mailbox: errors");
        $finish;
      end
    end
  end

  // Sender gaps: mostly none or short, now and then long. In steady stretches the
  // words follow back to back, so that a new word meets the block in every phase.
  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 49) == 0) steady = ~steady;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(20, 45);
  endfunction

  // Presents one word from a falling edge and holds it until the block takes it.
  // Inputs only ever change at falling edges; start stays high between words that
  // follow without a gap.
  task automatic put_word(input kind_t k, input logic [QID_W-1:0] qid,
                          input logic [TAG_W-1:0] from, input logic [TAG_W-1:0] tag,
                          input logic [DATA_W-1:0] data, input logic [LEN_W-1:0] slen,
                          input logic [LEN_W-1:0] rlim);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start       = 1'b1;
    kind        = k;
    queue_id    = qid;
    sender      = from;
    msg_type    = tag;
    payload     = data;
    send_length = slen;
    recv_limit  = rlim;
    do @(posedge clk); while (busy !== 1'b0);
    shadow.take_word(k, qid, from, tag, data, slen, rlim);
    @(negedge clk);
  endtask

  // Lengths lean towards the full word; the rest spread evenly, saturating values included.
  function automatic logic [LEN_W-1:0] rand_len();
    if ($urandom_range(0, 3) == 0) return LEN_W'(PAYLOAD_BYTES);
    return LEN_W'($urandom_range(0, 15));
  endfunction

  // The fields that an operation ignores are still randomised, so that a block
  // leaking them into a reply is caught.
  task automatic send_to(input int id);
    put_word(KIND_SEND, QID_W'(id), TAG_W'($urandom), TAG_W'($urandom),
             {$urandom, $urandom}, rand_len(), LEN_W'($urandom_range(0, 15)));
  endtask

  task automatic recv_from(input int id);
    put_word(KIND_RECV, QID_W'(id), TAG_W'($urandom), TAG_W'($urandom),
             {$urandom, $urandom}, LEN_W'($urandom_range(0, 15)), rand_len());
  endtask

  task automatic destroy_queue(input int id);
    put_word(KIND_DESTROY, QID_W'(id), TAG_W'($urandom), TAG_W'($urandom),
             {$urandom, $urandom}, LEN_W'($urandom_range(0, 15)),
             LEN_W'($urandom_range(0, 15)));
  endtask

  task automatic create_queue();
    put_word(KIND_CREATE, QID_W'($urandom_range(0, 31)), TAG_W'($urandom),
             TAG_W'($urandom), {$urandom, $urandom}, LEN_W'($urandom_range(0, 15)),
             LEN_W'($urandom_range(0, 15)));
  endtask

  // Directed opening: refusals on bad and free ids, the saturating and zero send
  // lengths, receive limits of zero, partial and above the word size, an empty
  // queue, and a recreated queue that must start empty.
  task automatic directed_words();
    recv_from(0);
    send_to(31);
    destroy_queue(NUM_QUEUES);
    create_queue();
    put_word(KIND_SEND, 5'd1, 16'hFFFF, 16'hFFFF, '1, 4'd15, 4'd0);
    put_word(KIND_SEND, 5'd1, 16'h0000, 16'h0000, '1, 4'd0, 4'd15);
    put_word(KIND_SEND, 5'd1, 16'h5A5A, 16'hA5A5, '1, 4'd3, 4'd0);
    put_word(KIND_SEND, 5'd1, 16'h1234, 16'hFEDC, 64'h0123_4567_89AB_CDEF, 4'd8, 4'd0);
    put_word(KIND_RECV, 5'd1, '0, '0, '0, 4'd0, 4'd15);
    put_word(KIND_RECV, 5'd1, '1, '1, '1, 4'd15, 4'd8);
    put_word(KIND_RECV, 5'd1, '0, '0, '0, 4'd0, 4'd0);
    put_word(KIND_RECV, 5'd1, '0, '0, '0, 4'd0, 4'd2);
    recv_from(1);
    create_queue();
    send_to(2);
    destroy_queue(1);
    send_to(1);
    create_queue();
    recv_from(1);
    destroy_queue(2);
    destroy_queue(2);
    create_queue();
    recv_from(2);
    recv_from(NUM_QUEUES + 1);
  endtask

  // Randomised traffic built from short scenarios on live queues: mixed sends and
  // receives, filling a queue past full, draining it past empty, creating until the
  // table is exhausted, destroying, recreating, and a share of wholly random words.
  task automatic random_traffic(input int n);
    int stop_at;
    int pick;
    int q;
    int reps;
    stop_at = shadow.words + n;
    while (shadow.words < stop_at) begin
      pick = $urandom_range(0, 99);
      q = shadow.pick_live();
      if (q == 0 && pick < 82) begin
        create_queue();
      end else if (pick < 30) begin
        reps = $urandom_range(1, 6);
        repeat (reps) begin
          if ($urandom_range(0, 2) != 0) send_to(q);
          else recv_from(q);
        end
      end else if (pick < 42) begin
        reps = SLOTS_PER_QUEUE - shadow.fill_of(q) + $urandom_range(1, 2);
        repeat (reps) send_to(q);
      end else if (pick < 54) begin
        reps = shadow.fill_of(q) + $urandom_range(1, 2);
        repeat (reps) recv_from(q);
      end else if (pick < 62) begin
        reps = shadow.free_count() + 1;
        repeat (reps) create_queue();
      end else if (pick < 72) begin
        destroy_queue(q);
        if ($urandom_range(0, 3) == 0) destroy_queue(q);
      end else if (pick < 82) begin
        // A queue is destroyed, perhaps holding messages, and the queue created next must come back empty.
        destroy_queue(q);
        create_queue();
        recv_from(shadow.last_new_id);
      end else begin
        put_word(kind_t'($urandom_range(0, 3)), QID_W'($urandom_range(0, 31)),
                 TAG_W'($urandom), TAG_W'($urandom), {$urandom, $urandom},
                 LEN_W'($urandom_range(0, 15)), LEN_W'($urandom_range(0, 15)));
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    kind        = KIND_CREATE;
    queue_id    = '0;
    sender      = '0;
    msg_type    = '0;
    payload     = '0;
    send_length = '0;
    recv_limit  = '0;
    steady      = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_words();
    random_traffic(RANDOM_WORDS);
    start = 1'b0;

    // Drain the outstanding replies, then keep watching for strays.
    while (shadow.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d words: %0d create, %0d send, %0d receive, %0d destroy.",
             shadow.words, shadow.ops_seen[KIND_CREATE], shadow.ops_seen[KIND_SEND],
             shadow.ops_seen[KIND_RECV], shadow.ops_seen[KIND_DESTROY]);
    $display("Refusals seen: %0d bad id, %0d queue full, %0d queue empty, %0d table full.",
             shadow.bad_id_refusals, shadow.full_refusals, shadow.empty_refusals,
             shadow.no_free_refusals);
    if (shadow.errors == 0) begin
      $display("tb_multi_queue_mailbox: clean");
    end else begin
      $display("tb_multi_queue_mailbox: errors");
    end
    $finish;
  end

endmodule
